>>> rtl/slfb_pkg.sv
// shared types and constants for the status led fault blinker
`timescale 1ns / 1ps

package slfb_pkg;

  localparam int MAX_LEDS    = 8;
  localparam int PHASE_TICKS = 13;
  localparam int EMIT_CAP    = 8;
  localparam int EMIT_LIMIT  = (MAX_LEDS < EMIT_CAP) ? MAX_LEDS : EMIT_CAP;

  localparam int OPCODE_W = 2;
  localparam int LED_W    = 3;
  localparam int TIMER_W  = 16;
  localparam int MODE_W   = 3;
  localparam int COLOR_W  = 8;
  localparam int COUNT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int SUB_W   = $clog2(PHASE_TICKS + 1);

  // input opcodes
  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REPORT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_EMIT   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_WRAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEDS_IN_USE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] TICK_WRAP_RST    = 16'd50;
  localparam logic [COUNT_W-1:0]    LEDS_IN_USE_RST  = 4'd8;
  localparam logic [COLOR_W-1:0]    BRIGHTNESS_RST   = 8'd225;

  // colour modes
  localparam logic [MODE_W-1:0] MODE_RED   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GREEN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BLUE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ALT   = 3'd3;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MARK = 2'd1,
    CMD_EMIT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [LED_W-1:0]   led;
    logic [MODE_W-1:0]  mode;
  } cmd_t;

endpackage

>>> rtl/status_led_fault_blinker_core.sv
// top level of the status led fault blinker
`timescale 1ns / 1ps

// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_ready   | opcode, led_select, timeout, flag, mode
// out_     | output    | out_valid / out_ready | led_number, red, green, blue, any_fault, last
// cfg_     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// every request is taken while the four-entry command queue has room
// tick start and faulted device reports are each taken by the led engine in its idle state
// end of tick starts a walk over the leds in use (at most eight), one result per
// cycle through the output register; a stalled output holds the walk, the queue
// keeps filling
// healthy reports, unused leds and the spare opcode are dropped at the decoder
// reset is synchronous active low: tick counter, fault marks and queue clear at once,
// registers return to period 50, eight leds, brightness 225

module status_led_fault_blinker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // request input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [slfb_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [slfb_pkg::LED_W-1:0]      in_led_select,
  input  logic [slfb_pkg::TIMER_W-1:0]    in_timeout_value,
  input  logic [slfb_pkg::TIMER_W-1:0]    in_timeout_threshold,
  input  logic                            in_timeout_watched,
  input  logic                            in_flag_watched,
  input  logic                            in_flag_ok,
  input  logic [slfb_pkg::MODE_W-1:0]     in_color_mode,
  // per-led result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [slfb_pkg::LED_W-1:0]      out_led_number,
  output logic [slfb_pkg::COLOR_W-1:0]    out_red,
  output logic [slfb_pkg::COLOR_W-1:0]    out_green,
  output logic [slfb_pkg::COLOR_W-1:0]    out_blue,
  output logic                            out_any_fault,
  output logic                            out_last,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slfb_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [slfb_pkg::CFG_DATA_W-1:0] tick_wrap_r, tick_wrap_nxt;
  logic [slfb_pkg::COUNT_W-1:0]    leds_in_use_r, leds_in_use_nxt;
  logic [slfb_pkg::COLOR_W-1:0]    brightness_r, brightness_nxt;

  logic           push;
  slfb_pkg::cmd_t push_cmd;
  logic           pop;
  slfb_pkg::cmd_t head_cmd;
  logic           not_empty;
  logic           fifo_full;

  // register file: always ready, unknown indexes ignored
  assign cfg_ready = 1'b1;

  always_comb begin
    tick_wrap_nxt    = tick_wrap_r;
    leds_in_use_nxt  = leds_in_use_r;
    brightness_nxt   = brightness_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        slfb_pkg::CFG_TICK_WRAP:    tick_wrap_nxt    = cfg_data;
        slfb_pkg::CFG_LEDS_IN_USE:  leds_in_use_nxt  = cfg_data[slfb_pkg::COUNT_W-1:0];
        slfb_pkg::CFG_BRIGHTNESS:   brightness_nxt   = cfg_data[slfb_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_wrap_r    <= slfb_pkg::TICK_WRAP_RST;
      leds_in_use_r  <= slfb_pkg::LEDS_IN_USE_RST;
      brightness_r   <= slfb_pkg::BRIGHTNESS_RST;
    end else begin
      tick_wrap_r    <= tick_wrap_nxt;
      leds_in_use_r  <= leds_in_use_nxt;
      brightness_r   <= brightness_nxt;
    end
  end

  // decoder: classifies each request and drops the ones that change nothing
  slfb_front u_front (
    .in_valid_opcode      (in_opcode),
    .in_valid             (in_valid),
    .in_led_select        (in_led_select),
    .in_timeout_value     (in_timeout_value),
    .in_timeout_threshold (in_timeout_threshold),
    .in_timeout_watched   (in_timeout_watched),
    .in_flag_watched      (in_flag_watched),
    .in_flag_ok           (in_flag_ok),
    .in_color_mode        (in_color_mode),
    .leds_in_use          (leds_in_use_r),
    .fifo_full            (fifo_full),
    .in_ready             (in_ready),
    .push                 (push),
    .push_cmd             (push_cmd)
  );

  // decouples request intake from the led walk
  slfb_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (not_empty),
    .full      (fifo_full)
  );

  // tick counter, blink phase, fault marks and result walk
  slfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_cmd       (head_cmd),
    .not_empty      (not_empty),
    .pop            (pop),
    .tick_wrap      (tick_wrap_r),
    .leds_in_use    (leds_in_use_r),
    .brightness     (brightness_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_led_number (out_led_number),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_any_fault  (out_any_fault),
    .out_last       (out_last)
  );

endmodule

>>> rtl/slfb_front.sv
// request decoder: fault check and command classification
`timescale 1ns / 1ps

module slfb_front (
  input  logic [slfb_pkg::OPCODE_W-1:0] in_valid_opcode,
  input  logic                          in_valid,
  input  logic [slfb_pkg::LED_W-1:0]    in_led_select,
  input  logic [slfb_pkg::TIMER_W-1:0]  in_timeout_value,
  input  logic [slfb_pkg::TIMER_W-1:0]  in_timeout_threshold,
  input  logic                          in_timeout_watched,
  input  logic                          in_flag_watched,
  input  logic                          in_flag_ok,
  input  logic [slfb_pkg::MODE_W-1:0]   in_color_mode,
  input  logic [slfb_pkg::COUNT_W-1:0]  leds_in_use,
  input  logic                          fifo_full,
  output logic                          in_ready,
  output logic                          push,
  output slfb_pkg::cmd_t                push_cmd
);

  logic fault;
  logic led_ok;
  logic keep;

  assign fault = (in_timeout_watched && (in_timeout_value > in_timeout_threshold)) ||
                 (in_flag_watched && !in_flag_ok);

  assign led_ok = ({1'b0, in_led_select} < leds_in_use) &&
                  (32'(in_led_select) < slfb_pkg::MAX_LEDS);

  always_comb begin
    keep          = 1'b0;
    push_cmd.kind = slfb_pkg::CMD_TICK;
    push_cmd.led  = in_led_select;
    push_cmd.mode = in_color_mode;
    unique case (in_valid_opcode)
      slfb_pkg::OP_TICK: begin
        keep = 1'b1;
      end
      slfb_pkg::OP_REPORT: begin
        // healthy devices and unused leds leave no trace
        keep          = fault && led_ok;
        push_cmd.kind = slfb_pkg::CMD_MARK;
      end
      slfb_pkg::OP_EMIT: begin
        keep          = 1'b1;
        push_cmd.kind = slfb_pkg::CMD_EMIT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = !fifo_full;
  assign push     = in_valid && !fifo_full && keep;

endmodule

>>> rtl/slfb_cmd_fifo.sv
// short command queue between decoder and led engine
`timescale 1ns / 1ps

module slfb_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  slfb_pkg::cmd_t push_cmd,
  input  logic           pop,
  output slfb_pkg::cmd_t head_cmd,
  output logic           not_empty,
  output logic           full
);

  slfb_pkg::cmd_t                 entry_r [slfb_pkg::QDEPTH];
  logic [slfb_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [slfb_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [slfb_pkg::QCNT_W-1:0]    count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == slfb_pkg::QCNT_W'(slfb_pkg::QDEPTH));
  assign head_cmd  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= slfb_pkg::QCNT_W'(slfb_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("push lost");

endmodule

>>> rtl/slfb_back.sv
// led engine: tick counter, fault marks and per-led result walk
`timescale 1ns / 1ps

module slfb_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  slfb_pkg::cmd_t                 head_cmd,
  input  logic                           not_empty,
  output logic                           pop,
  input  logic [slfb_pkg::CFG_DATA_W-1:0] tick_wrap,
  input  logic [slfb_pkg::COUNT_W-1:0]   leds_in_use,
  input  logic [slfb_pkg::COLOR_W-1:0]   brightness,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [slfb_pkg::LED_W-1:0]     out_led_number,
  output logic [slfb_pkg::COLOR_W-1:0]   out_red,
  output logic [slfb_pkg::COLOR_W-1:0]   out_green,
  output logic [slfb_pkg::COLOR_W-1:0]   out_blue,
  output logic                           out_any_fault,
  output logic                           out_last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } back_state_t;

  back_state_t                        state_r, state_nxt;
  logic [slfb_pkg::TIMER_W-1:0]       tick_r, tick_nxt;
  logic [slfb_pkg::SUB_W-1:0]         sub_r, sub_nxt;
  logic [1:0]                         phase_r, phase_nxt;
  logic [slfb_pkg::MAX_LEDS-1:0]      faulted_r, faulted_nxt;
  logic [slfb_pkg::MODE_W-1:0]        mode_r [slfb_pkg::MAX_LEDS];
  logic [slfb_pkg::MODE_W-1:0]        mode_nxt [slfb_pkg::MAX_LEDS];
  logic                               seen_r, seen_nxt;
  logic [slfb_pkg::LED_W-1:0]         idx_r, idx_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [slfb_pkg::LED_W-1:0]         led_number_r;
  logic [slfb_pkg::COLOR_W-1:0]       red_r, green_r, blue_r;
  logic                               any_fault_r, last_r;

  logic [slfb_pkg::TIMER_W:0]         tick_inc;
  logic [slfb_pkg::COUNT_W-1:0]       emit_n;
  logic                               is_last;
  logic                               load;
  logic                               out_free;
  logic                               lit;
  logic [slfb_pkg::COLOR_W-1:0]       red_c, green_c, blue_c;

  assign tick_inc = {1'b0, tick_r} + 1'b1;
  assign emit_n   = (leds_in_use > slfb_pkg::COUNT_W'(slfb_pkg::EMIT_LIMIT)) ?
                    slfb_pkg::COUNT_W'(slfb_pkg::EMIT_LIMIT) : leds_in_use;
  assign is_last  = (({1'b0, idx_r} + 1'b1) == emit_n);
  assign out_free = !out_valid_r || out_ready;

  // colour of the led under the walk index
  always_comb begin
    red_c   = '0;
    green_c = '0;
    blue_c  = '0;
    lit     = faulted_r[idx_r] && phase_r[0];
    if (lit) begin
      case (mode_r[idx_r])
        slfb_pkg::MODE_RED:   red_c   = brightness;
        slfb_pkg::MODE_GREEN: green_c = brightness;
        slfb_pkg::MODE_BLUE:  blue_c  = brightness;
        slfb_pkg::MODE_ALT: begin
          if (phase_r[1]) begin
            green_c = brightness;
          end else begin
            red_c = brightness;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    tick_nxt    = tick_r;
    sub_nxt     = sub_r;
    phase_nxt   = phase_r;
    faulted_nxt = faulted_r;
    mode_nxt    = mode_r;
    seen_nxt    = seen_r;
    idx_nxt     = idx_r;
    pop         = 1'b0;
    load        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (not_empty) begin
          pop = 1'b1;
          case (head_cmd.kind)
            slfb_pkg::CMD_TICK: begin
              if (tick_inc[slfb_pkg::TIMER_W] ||
                  (tick_inc[slfb_pkg::TIMER_W-1:0] >= tick_wrap)) begin
                tick_nxt  = '0;
                sub_nxt   = '0;
                phase_nxt = '0;
              end else begin
                tick_nxt = tick_inc[slfb_pkg::TIMER_W-1:0];
                if (sub_r == slfb_pkg::SUB_W'(slfb_pkg::PHASE_TICKS - 1)) begin
                  sub_nxt   = '0;
                  phase_nxt = phase_r + 1'b1;
                end else begin
                  sub_nxt = sub_r + 1'b1;
                end
              end
              faulted_nxt = '0;
              for (int i = 0; i < slfb_pkg::MAX_LEDS; i++) begin
                mode_nxt[i] = '0;
              end
              seen_nxt = 1'b0;
            end
            slfb_pkg::CMD_MARK: begin
              // first faulted device of the tick wins
              if (!faulted_r[head_cmd.led]) begin
                faulted_nxt[head_cmd.led] = 1'b1;
                mode_nxt[head_cmd.led]    = head_cmd.mode;
              end
              seen_nxt = 1'b1;
            end
            slfb_pkg::CMD_EMIT: begin
              idx_nxt = '0;
              if (emit_n != '0) begin
                state_nxt = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      sub_r       <= '0;
      phase_r     <= '0;
      faulted_r   <= '0;
      seen_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < slfb_pkg::MAX_LEDS; i++) begin
        mode_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      sub_r       <= sub_nxt;
      phase_r     <= phase_nxt;
      faulted_r   <= faulted_nxt;
      seen_r      <= seen_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      led_number_r <= idx_r;
      red_r        <= red_c;
      green_r      <= green_c;
      blue_r       <= blue_c;
      any_fault_r  <= seen_r;
      last_r       <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_number = led_number_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_any_fault  = any_fault_r;
  assign out_last       = last_r;

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ({1'b0, idx_r} < emit_n))
    else $error("led walk index past emit count");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (load && is_last) |=> (state_r == ST_IDLE))
    else $error("walk did not end after last led");

  a_no_pop_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !pop)
    else $error("command taken during led walk");

  a_phase_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_r == '0) |-> (sub_r == '0 && phase_r == '0))
    else $error("phase counter out of step with tick counter");

endmodule

>>> sim/status_led_fault_blinker_core_tb.sv
// self-checking testbench for the status led fault blinker core
`timescale 1ns / 1ps

module status_led_fault_blinker_core_tb;
  import slfb_pkg::*;

  // spare opcode, dropped by the block
  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
  // cycles to let queued ticks and reports settle before touching registers
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [LED_W-1:0]    led;
    logic [TIMER_W-1:0]  tmo_value;
    logic [TIMER_W-1:0]  tmo_limit;
    logic                tmo_watched;
    logic                flag_watched;
    logic                flag_ok;
    logic [MODE_W-1:0]   mode;
  } led_request_t;

  typedef struct packed {
    logic [LED_W-1:0]   led;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               any_fault;
    logic               last;
  } led_color_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid             = 1'b0;
  logic                  in_ready;
  logic [OPCODE_W-1:0]   in_opcode            = OP_TICK;
  logic [LED_W-1:0]      in_led_select        = '0;
  logic [TIMER_W-1:0]    in_timeout_value     = '0;
  logic [TIMER_W-1:0]    in_timeout_threshold = '0;
  logic                  in_timeout_watched   = 1'b0;
  logic                  in_flag_watched      = 1'b0;
  logic                  in_flag_ok           = 1'b0;
  logic [MODE_W-1:0]     in_color_mode        = MODE_RED;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [LED_W-1:0]      out_led_number;
  logic [COLOR_W-1:0]    out_red;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_blue;
  logic                  out_any_fault;
  logic                  out_last;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TICK_WRAP;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // shadow of the block: tick counter, per-led marks and registers
  logic [TIMER_W-1:0]    tick_now;
  logic [MAX_LEDS-1:0]   led_marked;
  logic [MODE_W-1:0]     led_mode [MAX_LEDS];
  logic                  tick_fault;
  logic [CFG_DATA_W-1:0] period_reg;
  logic [COUNT_W-1:0]    leds_reg;
  logic [COLOR_W-1:0]    bright_reg;

  led_color_t pending_colors[$];

  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int hold_cycles     = 0;
  int fail_count      = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int ticks_sent      = 0;

  status_led_fault_blinker_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_led_select        (in_led_select),
    .in_timeout_value     (in_timeout_value),
    .in_timeout_threshold (in_timeout_threshold),
    .in_timeout_watched   (in_timeout_watched),
    .in_flag_watched      (in_flag_watched),
    .in_flag_ok           (in_flag_ok),
    .in_color_mode        (in_color_mode),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_led_number       (out_led_number),
    .out_red              (out_red),
    .out_green            (out_green),
    .out_blue             (out_blue),
    .out_any_fault        (out_any_fault),
    .out_last             (out_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endfunction

  // advance the shadow by one accepted request, queueing the led colors it yields
  function automatic void predict_led_colors(led_request_t rq);
    int unsigned n;
    int unsigned phase;
    logic        faulted;
    led_color_t  res;
    case (rq.opcode)
      OP_TICK: begin
        tick_now = tick_now + 1'b1;
        if (tick_now >= period_reg) tick_now = '0;
        led_marked = '0;
        foreach (led_mode[i]) led_mode[i] = MODE_RED;
        tick_fault = 1'b0;
        ticks_sent++;
      end
      OP_REPORT: begin
        faulted = (rq.tmo_watched && rq.tmo_value > rq.tmo_limit) ||
                  (rq.flag_watched && !rq.flag_ok);
        // reports for leds beyond the ones in use are dropped
        if (rq.led < leds_reg && faulted) begin
          // first faulted device of the tick owns the color
          if (!led_marked[rq.led]) begin
            led_marked[rq.led] = 1'b1;
            led_mode[rq.led]   = rq.mode;
          end
          tick_fault = 1'b1;
        end
      end
      OP_EMIT: begin
        n = (leds_reg > EMIT_LIMIT) ? EMIT_LIMIT : leds_reg;
        phase = tick_now / PHASE_TICKS;
        for (int unsigned i = 0; i < n; i++) begin
          res = '0;
          res.led = LED_W'(i);
          // lit only on odd blink phases
          if (led_marked[i] && phase[0]) begin
            case (led_mode[i])
              MODE_RED:   res.red   = bright_reg;
              MODE_GREEN: res.green = bright_reg;
              MODE_BLUE:  res.blue  = bright_reg;
              MODE_ALT: begin
                if (phase % 4 == 1) res.red = bright_reg;
                else res.green = bright_reg;
              end
              default: ;
            endcase
          end
          res.any_fault = tick_fault;
          res.last = (i + 1 == n);
          pending_colors.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  // receiver: long hold-off when asked, otherwise random stalls
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else
      out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare every accepted led result against the oldest prediction
  always @(posedge clk) begin : check_results
    led_color_t want;
    led_color_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_led_number, out_red, out_green, out_blue, out_any_fault, out_last};
      if (pending_colors.size() == 0) begin
        note_failure($sformatf("unexpected result for led %0d", out_led_number));
      end else begin
        want = pending_colors.pop_front();
        results_checked++;
        if (got.led !== want.led || got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.any_fault !== want.any_fault ||
            got.last !== want.last)
          note_failure({
            $sformatf("expected led %0d rgb %0d/%0d/%0d fault %0b last %0b",
                      want.led, want.red, want.green, want.blue, want.any_fault,
                      want.last),
            $sformatf(", got led %0d rgb %0d/%0d/%0d fault %0b last %0b",
                      got.led, got.red, got.green, got.blue, got.any_fault,
                      got.last)});
      end
    end
  end

  // offer one request, holding it until taken
  task automatic send_request(led_request_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_opcode            <= rq.opcode;
    in_led_select        <= rq.led;
    in_timeout_value     <= rq.tmo_value;
    in_timeout_threshold <= rq.tmo_limit;
    in_timeout_watched   <= rq.tmo_watched;
    in_flag_watched      <= rq.flag_watched;
    in_flag_ok           <= rq.flag_ok;
    in_color_mode        <= rq.mode;
    do @(posedge clk); while (!in_ready);
    predict_led_colors(rq);
    requests_sent++;
  endtask

  // stop sending and let every predicted result and queued request drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // keeps cfg_valid high so back-to-back writes never drop it in between
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TICK_WRAP:    period_reg = value;
      CFG_LEDS_IN_USE:  leds_reg   = value[COUNT_W-1:0];
      CFG_BRIGHTNESS:   bright_reg = value[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry noise, the block keeps only the low bits
  task automatic configure(logic [CFG_DATA_W-1:0] period, logic [COUNT_W-1:0] leds,
                           logic [COLOR_W-1:0] bright);
    wait_idle();
    write_register(CFG_TICK_WRAP, period);
    write_register(CFG_LEDS_IN_USE, {12'($urandom), leds});
    write_register(CFG_BRIGHTNESS, {8'($urandom), bright});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic led_request_t random_request(logic [OPCODE_W-1:0] op);
    led_request_t rq;
    rq.opcode       = op;
    rq.led          = LED_W'($urandom);
    rq.tmo_value    = TIMER_W'($urandom);
    rq.tmo_limit    = TIMER_W'($urandom);
    rq.tmo_watched  = 1'($urandom);
    rq.flag_watched = 1'($urandom);
    rq.flag_ok      = 1'($urandom);
    rq.mode         = MODE_W'($urandom);
    return rq;
  endfunction

  // device report aimed mostly at leds in use, with limits near the value
  function automatic led_request_t random_report();
    led_request_t rq;
    int unsigned  span;
    rq = random_request(OP_REPORT);
    span = (leds_reg > EMIT_LIMIT) ? EMIT_LIMIT : leds_reg;
    if (span > 0 && $urandom_range(99) < 85) rq.led = LED_W'($urandom_range(span - 1));
    if ($urandom_range(1)) rq.tmo_limit = rq.tmo_value + TIMER_W'($urandom_range(4)) - 16'd2;
    if ($urandom_range(99) < 70) rq.mode = MODE_W'($urandom_range(3));
    return rq;
  endfunction

  function automatic led_request_t make_report(logic [LED_W-1:0] led,
                                               logic [TIMER_W-1:0] value,
                                               logic [TIMER_W-1:0] limit,
                                               logic watch_tmo, logic watch_flag,
                                               logic flag, logic [MODE_W-1:0] mode);
    led_request_t rq;
    rq = '{OP_REPORT, led, value, limit, watch_tmo, watch_flag, flag, mode};
    return rq;
  endfunction

  // emit straight after reset: every led dark, no fault
  task automatic test_reset_state();
    send_request(random_request(OP_EMIT));
  endtask

  // timeout and flag rules at their edges, first-fault-wins, spare opcode, repeated emit
  task automatic test_fault_rules();
    send_request(random_request(OP_TICK));
    send_request(make_report(3'd0, 16'hFFFF, 16'hFFFE, 1'b1, 1'b0, 1'b1, MODE_RED));
    send_request(make_report(3'd1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, MODE_GREEN));
    send_request(make_report(3'd2, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, MODE_BLUE));
    send_request(make_report(3'd3, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, MODE_BLUE));
    send_request(make_report(3'd4, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b0, 3'd7));
    send_request(make_report(3'd0, 16'h0001, 16'h0000, 1'b1, 1'b1, 1'b0, MODE_GREEN));
    send_request(make_report(3'd7, 16'h0001, 16'h0000, 1'b1, 1'b0, 1'b1, MODE_ALT));
    send_request(make_report(3'd5, 16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b0, MODE_BLUE));
    send_request(random_request(OP_SPARE));
    send_request(random_request(OP_EMIT));
    send_request(random_request(OP_EMIT));
  endtask

  // reports past the leds in use are dropped; zero leds in use emits nothing
  task automatic test_led_limits();
    configure(TICK_WRAP_RST, 4'd3, BRIGHTNESS_RST);
    send_request(random_request(OP_TICK));
    send_request(make_report(3'd5, 16'h0010, 16'h0001, 1'b1, 1'b1, 1'b0, MODE_RED));
    send_request(make_report(3'd2, 16'h0010, 16'h0001, 1'b1, 1'b0, 1'b1, MODE_BLUE));
    send_request(random_request(OP_EMIT));
    configure(TICK_WRAP_RST, 4'd0, BRIGHTNESS_RST);
    send_request(random_request(OP_EMIT));
  endtask

  // mostly well-formed ticks, with tick bursts, broken sequences and noise mixed in
  task automatic test_random_traffic(int n_items, int idle_pct, int stall_set);
    int start;
    int roll;
    send_idle_pct = idle_pct;
    stall_pct = stall_set;
    start = requests_sent;
    while (requests_sent - start < n_items) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_request(random_request(OPCODE_W'($urandom)));
      end else if (roll < 20) begin
        repeat ($urandom_range(5, 1)) send_request(random_request(OP_TICK));
      end else if (roll < 27) begin
        repeat ($urandom_range(3, 1)) send_request(random_report());
        if ($urandom_range(1)) send_request(random_request(OP_EMIT));
      end else begin
        send_request(random_request(OP_TICK));
        repeat ($urandom_range(5)) send_request(random_report());
        send_request(random_request(OP_EMIT));
        if ($urandom_range(4) == 0) send_request(random_request(OP_EMIT));
      end
    end
  endtask

  // receiver holds off for a long stretch while emits pile up behind it
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    send_request(random_request(OP_TICK));
    repeat (4) send_request(random_report());
    repeat (6) send_request(random_request(OP_EMIT));
    // pause until every result of the backlog has come out
    wait_idle();
    send_request(random_request(OP_TICK));
    repeat (3) send_request(random_report());
    send_request(random_request(OP_EMIT));
  endtask

  initial begin
    tick_now   = '0;
    led_marked = '0;
    foreach (led_mode[i]) led_mode[i] = MODE_RED;
    tick_fault = 1'b0;
    period_reg = TICK_WRAP_RST;
    leds_reg   = LEDS_IN_USE_RST;
    bright_reg = BRIGHTNESS_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_fault_rules();
    test_led_limits();

    configure(TICK_WRAP_RST, 4'd8, BRIGHTNESS_RST);
    test_random_traffic(95, 0, 0);
    configure(16'hFFFF, 4'hF, 8'hFF);
    test_random_traffic(95, 51, 0);
    configure(16'd27, 4'd5, 8'($urandom));
    test_random_traffic(95, 0, 51);
    configure(16'd0, 4'd1, 8'd0);
    test_random_traffic(75, 18, 18);
    configure(TICK_WRAP_RST, 4'd8, 8'($urandom));
    test_backpressure();
    configure(16'd1, 4'd7, 8'($urandom));
    test_random_traffic(40, 18, 18);
    configure(16'd45, 4'd6, 8'($urandom));
    test_random_traffic(35, 18, 18);

    wait_idle();

    $display("covered %0d requests over %0d ticks and %0d led results checked,",
             requests_sent, ticks_sent, results_checked);
    $display("periods 0 to 65535, leds in use 0 to 15, brightness 0 to 255, with stalls");
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> status_led_fault_blinker_core.f
rtl/slfb_pkg.sv
rtl/slfb_front.sv
rtl/slfb_cmd_fifo.sv
rtl/slfb_back.sv
rtl/status_led_fault_blinker_core.sv
sim/status_led_fault_blinker_core_tb.sv
